[rtl/core/wfpid_pkg.sv]
// Shared types and constants of the wall-following PID motor drive.
// Used by the interfaces, the register file, the divider, the top level and the checker.
`default_nettype none

package wfpid_pkg;

   localparam int REG_W       = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int SUM_W       = 17;
   localparam int DUTY_W      = 16;
   localparam int CV_W        = 17;
   localparam int CASE_W      = 3;
   localparam int DIV_NUM_W   = 32;
   localparam int DIV_DEN_W   = 16;

   localparam int ERR_OFFSET  = 120;
   localparam int NEAR_LIMIT  = 250;
   localparam int FIFTH_DIV   = 5;

   localparam logic [REG_W-1:0] GAIN_P_RESET         = 16'd256;
   localparam logic [REG_W-1:0] GAIN_I_RESET         = 16'd0;
   localparam logic [REG_W-1:0] GAIN_D_RESET         = 16'd0;
   localparam logic [REG_W-1:0] INTEGRAL_LIMIT_RESET = 16'd1000;
   localparam logic [REG_W-1:0] MAX_DIFFERENCE_RESET = 16'd100;
   localparam logic [REG_W-1:0] FULL_DUTY_RESET      = 16'd0;
   localparam logic [REG_W-1:0] TURN_TICKS_RESET     = 16'd200;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FOLLOW_SIDE    = 3'd0,
      CSR_GAIN_P         = 3'd1,
      CSR_GAIN_I         = 3'd2,
      CSR_GAIN_D         = 3'd3,
      CSR_INTEGRAL_LIMIT = 3'd4,
      CSR_MAX_DIFFERENCE = 3'd5,
      CSR_FULL_DUTY      = 3'd6,
      CSR_TURN_TICKS     = 3'd7
   } csr_index_type;

   typedef enum logic [CASE_W-1:0] {
      CASE_PIVOT     = 3'd0,
      CASE_CORNER    = 3'd1,
      CASE_HARD_TURN = 3'd2,
      CASE_LATE_ARC  = 3'd3,
      CASE_STEER     = 3'd4
   } drive_case_type;

   typedef struct packed {
      logic             follow_side;
      logic [REG_W-1:0] gain_p;
      logic [REG_W-1:0] gain_i;
      logic [REG_W-1:0] gain_d;
      logic [REG_W-1:0] integral_limit;
      logic [REG_W-1:0] max_difference;
      logic [REG_W-1:0] full_duty;
      logic [REG_W-1:0] turn_ticks;
   } cfg_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] numer;
      logic [DIV_DEN_W-1:0] denom;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quot;
   } div_rsp_type;

endpackage

`default_nettype wire

[rtl/core/wfpid_if.sv]
// Request and response channel interfaces of the wall-following motor drive.
// Depends on wfpid_pkg for field widths.
`default_nettype none

interface wfpid_req_if #(
   parameter int SENSOR_BITS = 10
);
   logic                   valid;
   logic                   ready;
   logic [SENSOR_BITS-1:0] left_sensor;
   logic [SENSOR_BITS-1:0] front_sensor;
   logic [SENSOR_BITS-1:0] right_sensor;

   modport source (output valid, output left_sensor, output front_sensor,
                   output right_sensor, input ready);
   modport sink   (input valid, input left_sensor, input front_sensor,
                   input right_sensor, output ready);
endinterface

interface wfpid_rsp_if;
   logic                                valid;
   logic                                ready;
   logic        [wfpid_pkg::DUTY_W-1:0] left_duty;
   logic        [wfpid_pkg::DUTY_W-1:0] right_duty;
   logic                                dir_a;
   logic                                dir_b;
   logic                                dir_c;
   logic                                dir_d;
   logic        [wfpid_pkg::CASE_W-1:0] drive_case;
   logic signed [wfpid_pkg::CV_W-1:0]   control_out;

   modport source (output valid, output left_duty, output right_duty, output dir_a,
                   output dir_b, output dir_c, output dir_d, output drive_case,
                   output control_out, input ready);
   modport sink   (input valid, input left_duty, input right_duty, input dir_a,
                   input dir_b, input dir_c, input dir_d, input drive_case,
                   input control_out, output ready);
endinterface

`default_nettype wire

[rtl/core/wfpid_csr.sv]
// Configuration register file of the wall-following motor drive.
// Depends on wfpid_pkg for the register index codes and the cfg_type bundle.
`default_nettype none

module wfpid_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [wfpid_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [wfpid_pkg::REG_W-1:0]         csr_wdata,
   output wfpid_pkg::cfg_type                  cfg
);

   wfpid_pkg::cfg_type cfg_ff;
   wfpid_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (wfpid_pkg::csr_index_type'(csr_index))
            wfpid_pkg::CSR_FOLLOW_SIDE:    cfg_in.follow_side    = csr_wdata[0];
            wfpid_pkg::CSR_GAIN_P:         cfg_in.gain_p         = csr_wdata;
            wfpid_pkg::CSR_GAIN_I:         cfg_in.gain_i         = csr_wdata;
            wfpid_pkg::CSR_GAIN_D:         cfg_in.gain_d         = csr_wdata;
            wfpid_pkg::CSR_INTEGRAL_LIMIT: cfg_in.integral_limit = csr_wdata;
            wfpid_pkg::CSR_MAX_DIFFERENCE: cfg_in.max_difference = csr_wdata;
            wfpid_pkg::CSR_FULL_DUTY:      cfg_in.full_duty      = csr_wdata;
            wfpid_pkg::CSR_TURN_TICKS:     cfg_in.turn_ticks     = csr_wdata;
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.follow_side    <= 1'b0;
         cfg_ff.gain_p         <= wfpid_pkg::GAIN_P_RESET;
         cfg_ff.gain_i         <= wfpid_pkg::GAIN_I_RESET;
         cfg_ff.gain_d         <= wfpid_pkg::GAIN_D_RESET;
         cfg_ff.integral_limit <= wfpid_pkg::INTEGRAL_LIMIT_RESET;
         cfg_ff.max_difference <= wfpid_pkg::MAX_DIFFERENCE_RESET;
         cfg_ff.full_duty      <= wfpid_pkg::FULL_DUTY_RESET;
         cfg_ff.turn_ticks     <= wfpid_pkg::TURN_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[rtl/core/wfpid_mul.sv]
// Shared signed multiplier with a registered product.
// Stand-alone; operand widths come from the instantiating module.
`default_nettype none

module wfpid_mul #(
   parameter int A_W = 18,
   parameter int B_W = 17
) (
   input  logic                      clock,
   input  logic signed [A_W-1:0]     a,
   input  logic signed [B_W-1:0]     b,
   output logic signed [A_W+B_W-1:0] prod
);

   logic signed [A_W+B_W-1:0] prod_ff;
   logic signed [A_W+B_W-1:0] prod_in;

   assign prod_in = (A_W+B_W)'(a) * (A_W+B_W)'(b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

[rtl/core/wfpid_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on wfpid_pkg for div_req_type, div_rsp_type and operand widths.
`default_nettype none

module wfpid_div (
   input  logic                   clock,
   input  logic                   reset,
   input  wfpid_pkg::div_req_type req,
   output wfpid_pkg::div_rsp_type rsp
);

   localparam int NUM_W = wfpid_pkg::DIV_NUM_W;
   localparam int DEN_W = wfpid_pkg::DIV_DEN_W;
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] quot_ff, quot_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;

   logic [DEN_W:0]   rem_shift;
   logic [DEN_W:0]   rem_diff;
   logic             fits;

   assign rem_shift = {rem_ff, quot_ff[NUM_W-1]};
   assign rem_diff  = rem_shift - {1'b0, den_ff};
   assign fits      = rem_shift >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         quot_in = req.numer;
         rem_in  = '0;
         den_in  = req.denom;
      end else if (busy_ff) begin
         quot_in = {quot_ff[NUM_W-2:0], fits};
         rem_in  = fits ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;

endmodule

`default_nettype wire

[rtl/core/wall_follow_pid_motor_drive.sv]
// Top level of the wall-following PID motor drive: sequencer, PID state and drive choice.
// Depends on wfpid_pkg, wfpid_if, wfpid_csr, wfpid_mul and wfpid_div.
//
//   channel  | role   | handshake          | contents
//   req_bus  | sink   | valid/ready        | left, front and right sensor samples
//   rsp_bus  | source | valid/ready        | duties, direction pins, case, control value
//   csr_*    | write  | csr_wr_en strobe   | register index and 16-bit data
//
// The 32-step divider forms the fractional duties when a case needs one.
// The block takes one request at a time; the result waits in the output register.
// Reset is synchronous and restores the registers and the PID state.
`default_nettype none

module wall_follow_pid_motor_drive #(
   parameter int SENSOR_BITS    = 10,
   parameter int GAIN_FRAC_BITS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   wfpid_req_if.sink                         req_bus,
   wfpid_rsp_if.source                       rsp_bus,
   input  logic                              csr_wr_en,
   input  logic [wfpid_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [wfpid_pkg::REG_W-1:0]       csr_wdata
);

   localparam int REG_W     = wfpid_pkg::REG_W;
   localparam int SUM_W     = wfpid_pkg::SUM_W;
   localparam int CV_W      = wfpid_pkg::CV_W;
   localparam int DUTY_W    = wfpid_pkg::DUTY_W;
   localparam int NUM_W     = wfpid_pkg::DIV_NUM_W;
   localparam int DEN_W     = wfpid_pkg::DIV_DEN_W;
   localparam int ERR_W     = SENSOR_BITS + 1;
   localparam int DER_W     = SENSOR_BITS + 2;
   localparam int SUM_TMP_W = ((ERR_W > SUM_W) ? ERR_W : SUM_W) + 1;
   localparam int MUL_A_W   = (DER_W > SUM_W + 1) ? DER_W : SUM_W + 1;
   localparam int MUL_B_W   = REG_W + 1;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int ACC_W     = PROD_W + 2;

   localparam logic signed [ERR_W-1:0]       OFFSET_S = ERR_W'(wfpid_pkg::ERR_OFFSET);
   localparam logic        [SENSOR_BITS-1:0] NEAR_S   = SENSOR_BITS'(wfpid_pkg::NEAR_LIMIT);
   localparam logic        [DEN_W-1:0]       FIFTH_S  = DEN_W'(wfpid_pkg::FIFTH_DIV);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PID,
      ST_MUL_P,
      ST_MUL_I,
      ST_MUL_D,
      ST_ACC_D,
      ST_DECIDE,
      ST_DR_MUL,
      ST_DR_LATCH,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_DONE
   } state_type;

   wfpid_pkg::cfg_type     cfg;
   wfpid_pkg::div_req_type div_req;
   wfpid_pkg::div_rsp_type div_rsp;

   state_type                      state_ff, state_in;
   logic [SENSOR_BITS-1:0]         left_ff, left_in;
   logic [SENSOR_BITS-1:0]         front_ff, front_in;
   logic [SENSOR_BITS-1:0]         right_ff, right_in;
   logic signed [ERR_W-1:0]        err_ff, err_in;
   logic signed [DER_W-1:0]        deriv_ff, deriv_in;
   logic signed [SUM_W-1:0]        sum_ff, sum_in;
   logic signed [ERR_W-1:0]        prev_ff, prev_in;
   logic [REG_W-1:0]               turn_ff, turn_in;
   logic signed [ACC_W-1:0]        acc_ff, acc_in;
   logic signed [CV_W-1:0]         cv_ff, cv_in;
   logic [REG_W-1:0]               dr_diff_ff, dr_diff_in;
   logic [NUM_W-1:0]               numer_ff, numer_in;
   logic [DEN_W-1:0]               denom_ff, denom_in;
   logic                           tgt_right_ff, tgt_right_in;
   logic [DUTY_W-1:0]              ld_ff, ld_in;
   logic [DUTY_W-1:0]              rd_ff, rd_in;
   logic                           da_ff, da_in;
   logic                           db_ff, db_in;
   logic                           dc_ff, dc_in;
   logic                           dd_ff, dd_in;
   wfpid_pkg::drive_case_type      case_ff, case_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [DUTY_W-1:0]              rsp_ld_ff, rsp_ld_in;
   logic [DUTY_W-1:0]              rsp_rd_ff, rsp_rd_in;
   logic                           rsp_a_ff, rsp_a_in;
   logic                           rsp_b_ff, rsp_b_in;
   logic                           rsp_c_ff, rsp_c_in;
   logic                           rsp_d_ff, rsp_d_in;
   logic [wfpid_pkg::CASE_W-1:0]   rsp_case_ff, rsp_case_in;
   logic signed [CV_W-1:0]         rsp_cv_ff, rsp_cv_in;

   logic                           rside;
   logic [SENSOR_BITS-1:0]         wall;
   logic [SENSOR_BITS-1:0]         other;
   logic signed [ERR_W-1:0]        err_calc;
   logic signed [SUM_TMP_W-1:0]    sum_tmp;
   logic signed [SUM_TMP_W-1:0]    lim_s;
   logic signed [SUM_W-1:0]        sum_clamp;
   logic signed [DER_W-1:0]        deriv_calc;
   logic signed [MUL_A_W-1:0]      mul_a;
   logic signed [MUL_B_W-1:0]      mul_b;
   logic signed [PROD_W-1:0]       mul_prod;
   logic signed [ACC_W-1:0]        cv_full;
   logic signed [ACC_W-1:0]        maxd_s;
   logic signed [CV_W-1:0]         cv_clamp;
   logic [REG_W-1:0]               mag;
   logic [REG_W-1:0]               turn_inc;
   logic                           wall_near;
   logic                           front_near;
   logic                           other_far;
   logic                           cv_over;

   wfpid_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   wfpid_mul #(
      .A_W (MUL_A_W),
      .B_W (MUL_B_W)
   ) u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (mul_prod)
   );

   wfpid_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign rside = cfg.follow_side;
   assign wall  = rside ? right_ff : left_ff;
   assign other = rside ? left_ff : right_ff;

   assign err_calc   = signed'({1'b0, wall}) - OFFSET_S;
   assign sum_tmp    = SUM_TMP_W'(sum_ff) + SUM_TMP_W'(err_calc);
   assign lim_s      = SUM_TMP_W'(signed'({1'b0, cfg.integral_limit}));
   assign deriv_calc = DER_W'(err_calc) - DER_W'(prev_ff);

   always_comb begin
      if (sum_tmp > lim_s) begin
         sum_clamp = SUM_W'(lim_s);
      end else if (sum_tmp < -lim_s) begin
         sum_clamp = SUM_W'(-lim_s);
      end else begin
         sum_clamp = SUM_W'(sum_tmp);
      end
   end

   assign cv_full = acc_ff >>> GAIN_FRAC_BITS;
   assign maxd_s  = ACC_W'(signed'({1'b0, cfg.max_difference}));
   assign cv_over = cv_full > maxd_s;

   always_comb begin
      if (cv_over) begin
         cv_clamp = CV_W'(maxd_s);
      end else if (cv_full < -maxd_s) begin
         cv_clamp = CV_W'(-maxd_s);
      end else begin
         cv_clamp = CV_W'(cv_full);
      end
   end

   assign mag        = cv_clamp[CV_W-1] ? REG_W'(-cv_clamp) : REG_W'(cv_clamp);
   assign turn_inc   = (turn_ff != '1) ? turn_ff + REG_W'(1) : turn_ff;
   assign wall_near  = wall < NEAR_S;
   assign front_near = front_ff < NEAR_S;
   assign other_far  = other > NEAR_S;

   always_comb begin
      case (state_ff)
         ST_MUL_P: begin
            mul_a = MUL_A_W'(err_ff);
            mul_b = signed'({1'b0, cfg.gain_p});
         end
         ST_MUL_I: begin
            mul_a = MUL_A_W'(sum_ff);
            mul_b = signed'({1'b0, cfg.gain_i});
         end
         ST_MUL_D: begin
            mul_a = MUL_A_W'(deriv_ff);
            mul_b = signed'({1'b0, cfg.gain_d});
         end
         ST_DR_MUL: begin
            mul_a = MUL_A_W'(signed'({1'b0, dr_diff_ff}));
            mul_b = signed'({1'b0, cfg.full_duty});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign div_req.start = state_ff == ST_DIV_GO;
   assign div_req.numer = numer_ff;
   assign div_req.denom = denom_ff;

   always_comb begin
      state_in     = state_ff;
      left_in      = left_ff;
      front_in     = front_ff;
      right_in     = right_ff;
      err_in       = err_ff;
      deriv_in     = deriv_ff;
      sum_in       = sum_ff;
      prev_in      = prev_ff;
      turn_in      = turn_ff;
      acc_in       = acc_ff;
      cv_in        = cv_ff;
      dr_diff_in   = dr_diff_ff;
      numer_in     = numer_ff;
      denom_in     = denom_ff;
      tgt_right_in = tgt_right_ff;
      ld_in        = ld_ff;
      rd_in        = rd_ff;
      da_in        = da_ff;
      db_in        = db_ff;
      dc_in        = dc_ff;
      dd_in        = dd_ff;
      case_in      = case_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_ld_in    = rsp_ld_ff;
      rsp_rd_in    = rsp_rd_ff;
      rsp_a_in     = rsp_a_ff;
      rsp_b_in     = rsp_b_ff;
      rsp_c_in     = rsp_c_ff;
      rsp_d_in     = rsp_d_ff;
      rsp_case_in  = rsp_case_ff;
      rsp_cv_in    = rsp_cv_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               left_in  = req_bus.left_sensor;
               front_in = req_bus.front_sensor;
               right_in = req_bus.right_sensor;
               state_in = ST_PID;
            end
         end
         ST_PID: begin
            err_in   = err_calc;
            sum_in   = sum_clamp;
            deriv_in = deriv_calc;
            prev_in  = err_calc;
            state_in = ST_MUL_P;
         end
         ST_MUL_P: begin
            state_in = ST_MUL_I;
         end
         ST_MUL_I: begin
            acc_in   = ACC_W'(mul_prod);
            state_in = ST_MUL_D;
         end
         ST_MUL_D: begin
            acc_in   = acc_ff + ACC_W'(mul_prod);
            state_in = ST_ACC_D;
         end
         ST_ACC_D: begin
            acc_in   = acc_ff + ACC_W'(mul_prod);
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cv_in        = cv_clamp;
            ld_in        = cfg.full_duty;
            rd_in        = cfg.full_duty;
            da_in        = 1'b0;
            db_in        = 1'b1;
            dc_in        = 1'b0;
            dd_in        = 1'b1;
            tgt_right_in = rside;
            numer_in     = NUM_W'(cfg.full_duty);
            denom_in     = FIFTH_S;
            if (wall_near && front_near && other_far) begin
               case_in  = wfpid_pkg::CASE_PIVOT;
               da_in    = rside;
               dc_in    = !rside;
               state_in = ST_DONE;
            end else if (wall_near && front_near) begin
               case_in  = wfpid_pkg::CASE_CORNER;
               da_in    = rside;
               db_in    = !rside;
               dc_in    = !rside;
               dd_in    = rside;
               if (rside) begin
                  ld_in = cfg.full_duty >> 1;
               end else begin
                  rd_in = cfg.full_duty >> 1;
               end
               state_in = ST_DIV_GO;
            end else if (cv_over) begin
               turn_in = turn_inc;
               if (turn_inc <= cfg.turn_ticks) begin
                  case_in  = wfpid_pkg::CASE_HARD_TURN;
                  da_in    = !rside;
                  dc_in    = rside;
                  numer_in = NUM_W'({cfg.full_duty, 1'b0});
               end else begin
                  case_in  = wfpid_pkg::CASE_LATE_ARC;
               end
               state_in = ST_DIV_GO;
            end else begin
               case_in      = wfpid_pkg::CASE_STEER;
               turn_in      = '0;
               tgt_right_in = cv_clamp[CV_W-1] ^ rside;
               denom_in     = cfg.max_difference;
               dr_diff_in   = cfg.max_difference - mag;
               if (cfg.max_difference == '0) begin
                  if (cv_clamp[CV_W-1] ^ rside) begin
                     rd_in = '0;
                  end else begin
                     ld_in = '0;
                  end
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_DR_MUL;
               end
            end
         end
         ST_DR_MUL: begin
            state_in = ST_DR_LATCH;
         end
         ST_DR_LATCH: begin
            numer_in = mul_prod[NUM_W-1:0];
            state_in = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               if (tgt_right_ff) begin
                  rd_in = div_rsp.quot[DUTY_W-1:0];
               end else begin
                  ld_in = div_rsp.quot[DUTY_W-1:0];
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_ld_in    = ld_ff;
               rsp_rd_in    = rd_ff;
               rsp_a_in     = da_ff;
               rsp_b_in     = db_ff;
               rsp_c_in     = dc_ff;
               rsp_d_in     = dd_ff;
               rsp_case_in  = case_ff;
               rsp_cv_in    = cv_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         prev_ff      <= '0;
         turn_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         prev_ff      <= prev_in;
         turn_ff      <= turn_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      left_ff      <= left_in;
      front_ff     <= front_in;
      right_ff     <= right_in;
      err_ff       <= err_in;
      deriv_ff     <= deriv_in;
      acc_ff       <= acc_in;
      cv_ff        <= cv_in;
      dr_diff_ff   <= dr_diff_in;
      numer_ff     <= numer_in;
      denom_ff     <= denom_in;
      tgt_right_ff <= tgt_right_in;
      ld_ff        <= ld_in;
      rd_ff        <= rd_in;
      da_ff        <= da_in;
      db_ff        <= db_in;
      dc_ff        <= dc_in;
      dd_ff        <= dd_in;
      case_ff      <= case_in;
      rsp_ld_ff    <= rsp_ld_in;
      rsp_rd_ff    <= rsp_rd_in;
      rsp_a_ff     <= rsp_a_in;
      rsp_b_ff     <= rsp_b_in;
      rsp_c_ff     <= rsp_c_in;
      rsp_d_ff     <= rsp_d_in;
      rsp_case_ff  <= rsp_case_in;
      rsp_cv_ff    <= rsp_cv_in;
   end

   assign req_bus.ready       = state_ff == ST_IDLE;
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.left_duty   = rsp_ld_ff;
   assign rsp_bus.right_duty  = rsp_rd_ff;
   assign rsp_bus.dir_a       = rsp_a_ff;
   assign rsp_bus.dir_b       = rsp_b_ff;
   assign rsp_bus.dir_c       = rsp_c_ff;
   assign rsp_bus.dir_d       = rsp_d_ff;
   assign rsp_bus.drive_case  = rsp_case_ff;
   assign rsp_bus.control_out = rsp_cv_ff;

endmodule

`default_nettype wire

[rtl/core/wfpid_checker.sv]
// Port-level checks of the wall-following motor drive, bound to the top level.
// Depends on wfpid_pkg for the drive case codes.
`default_nettype none

module wfpid_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         dir_a,
   input logic                         dir_b,
   input logic                         dir_c,
   input logic                         dir_d,
   input logic [wfpid_pkg::CASE_W-1:0] drive_case
);

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a request is in work");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("stalled response dropped");

   a_pivot_dirs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && drive_case == wfpid_pkg::CASE_PIVOT
      |-> dir_b && dir_d && (dir_a != dir_c))
      else $error("pivot with wrong direction pins");

   a_forward_dirs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (drive_case == wfpid_pkg::CASE_STEER ||
                    drive_case == wfpid_pkg::CASE_LATE_ARC)
      |-> !dir_a && dir_b && !dir_c && dir_d)
      else $error("forward drive with wrong direction pins");

endmodule

bind wall_follow_pid_motor_drive wfpid_checker u_wfpid_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .dir_a      (rsp_bus.dir_a),
   .dir_b      (rsp_bus.dir_b),
   .dir_c      (rsp_bus.dir_c),
   .dir_d      (rsp_bus.dir_d),
   .drive_case (rsp_bus.drive_case)
);

`default_nettype wire
